@@ rtl/stun_response_address_parser_defines.svh @@
// ---------------------------------------------------------------------------
// stun response address parser - assertion macros
// shared concurrent check forms used at the end of the top level
// ---------------------------------------------------------------------------
`ifndef STUN_RESPONSE_ADDRESS_PARSER_DEFINES_SVH
`define STUN_RESPONSE_ADDRESS_PARSER_DEFINES_SVH

// condition in the same cycle
`define SRAP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srap check failed: same-cycle implication");

// condition in the next cycle
`define SRAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srap check failed: next-cycle implication");

`endif

@@ rtl/srap_pkg.sv @@
// ---------------------------------------------------------------------------
// srap_pkg
// status and kind codes, attribute types and the stun magic cookie
// ---------------------------------------------------------------------------
package srap_pkg;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_SHORT      = 3'd1,
    STATUS_BAD_TYPE   = 3'd2,
    STATUS_BAD_COOKIE = 3'd3,
    STATUS_OVERRUN    = 3'd4,
    STATUS_NO_ADDRESS = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_MAPPED  = 2'd0,
    KIND_XOR     = 2'd1,
    KIND_RELAYED = 2'd2
  } kind_t;

  localparam logic [15:0] ATTR_MAPPED   = 16'h0001;
  localparam logic [15:0] ATTR_XOR      = 16'h0020;
  localparam logic [15:0] ATTR_RELAYED  = 16'h0016;
  localparam logic [7:0]  FAMILY_IPV4   = 8'h01;

  localparam logic [15:0] TYPE_MASK     = 16'hFFFE;
  localparam logic [15:0] TYPE_BINDING  = 16'h0100;
  localparam logic [31:0] MAGIC_COOKIE  = 32'h2112A442;

  localparam int          HEADER_BYTES  = 20;
  localparam logic [16:0] POSITION_MAX  = 17'h1FFFF;

  // cookie byte expected at header offset 4 + idx
  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] res;
    case (idx)
      2'd0:    res = MAGIC_COOKIE[31:24];
      2'd1:    res = MAGIC_COOKIE[23:16];
      2'd2:    res = MAGIC_COOKIE[15:8];
      default: res = MAGIC_COOKIE[7:0];
    endcase
    return res;
  endfunction

endpackage

@@ rtl/stun_response_address_parser.sv @@
// ---------------------------------------------------------------------------
// stun_response_address_parser
// walks a stun binding response byte by byte and reports the mapped address
// ---------------------------------------------------------------------------
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------------------------
//   in       | in_valid/in_stall | data_byte, end_of_datagram
//   out      | out_valid/out_stall | status, mapped_ip, mapped_port,
//            |                   | address_kind
//
// one byte is taken every cycle unless in_stall is high; the result appears in the
// output register in the cycle after the last byte of a datagram is taken.
// rst (synchronous) clears the parser control state and empties the output register.
// the input stalls only when a final byte arrives while an earlier result
// is still held and stalled; other bytes keep flowing past a held result.
// ---------------------------------------------------------------------------
`include "stun_response_address_parser_defines.svh"

module stun_response_address_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_datagram,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] mapped_ip,
  output logic [15:0] mapped_port,
  output logic [1:0]  address_kind
);

  // parser state
  logic [16:0] byte_position, byte_position_next;
  logic [15:0] header_type, header_type_next;
  logic [15:0] header_length, header_length_next;
  logic        cookie_match, cookie_match_next;
  logic [17:0] next_attribute_start, next_attribute_start_next;
  logic [15:0] current_attr_type, current_attr_type_next;
  logic [15:0] current_attr_length, current_attr_length_next;
  logic [7:0]  value_family, value_family_next;
  logic [15:0] value_port, value_port_next;
  logic [31:0] value_address, value_address_next;
  logic        found_flag, found_flag_next;
  logic [31:0] found_ip, found_ip_next;
  logic [15:0] found_port, found_port_next;
  srap_pkg::kind_t found_kind, found_kind_next;

  logic        in_accept;
  logic        out_take;
  logic        walk_en;
  logic [18:0] msg_end;
  logic [18:0] attr_hdr_end;
  logic [17:0] attr_offset;
  logic [15:0] len_sel;
  logic [16:0] len_round;
  logic [17:0] padded_end;
  logic [31:0] addr_done;
  srap_pkg::status_t status_next;

  assign out_take  = out_valid && !out_stall;
  assign in_stall  = out_valid && out_stall && end_of_datagram;
  assign in_accept = in_valid && !in_stall;

  // attribute walk window
  assign msg_end      = 19'(header_length) + 19'(srap_pkg::HEADER_BYTES);
  assign attr_hdr_end = 19'(next_attribute_start) + 19'd4;
  assign walk_en      = (byte_position >= 17'(srap_pkg::HEADER_BYTES)) &&
                        (18'(byte_position) >= next_attribute_start) &&
                        (attr_hdr_end <= msg_end);
  assign attr_offset  = 18'(byte_position) - next_attribute_start;

  // length is completed by this byte at offset 3
  assign len_sel    = (attr_offset[3:0] == 4'd3) ? {current_attr_length[15:8], data_byte}
                                                 : current_attr_length;
  assign len_round  = (17'(len_sel) + 17'd3) & ~17'd3;
  assign padded_end = next_attribute_start + 18'd4 + 18'(len_round);
  assign addr_done  = {value_address[31:8], data_byte};

  always_comb begin
    header_type_next          = header_type;
    header_length_next        = header_length;
    cookie_match_next         = cookie_match;
    next_attribute_start_next = next_attribute_start;
    current_attr_type_next    = current_attr_type;
    current_attr_length_next  = current_attr_length;
    value_family_next         = value_family;
    value_port_next           = value_port;
    value_address_next        = value_address;
    found_flag_next           = found_flag;
    found_ip_next             = found_ip;
    found_port_next           = found_port;
    found_kind_next           = found_kind;

    case (byte_position)
      17'd0:   header_type_next   = {data_byte, 8'h00};
      17'd1:   header_type_next   = {header_type[15:8], data_byte};
      17'd2:   header_length_next = {data_byte, 8'h00};
      17'd3:   header_length_next = {header_length[15:8], data_byte};
      default: begin
        if (byte_position inside {[17'd4:17'd7]}) begin
          if (data_byte != srap_pkg::cookie_byte(byte_position[1:0])) begin
            cookie_match_next = 1'b0;
          end
        end
      end
    endcase

    if (walk_en && attr_offset < 18'd12) begin
      case (attr_offset[3:0])
        4'd0: current_attr_type_next = {data_byte, 8'h00};
        4'd1: current_attr_type_next = {current_attr_type[15:8], data_byte};
        4'd2: current_attr_length_next = {data_byte, 8'h00};
        4'd3: begin
          current_attr_length_next = len_sel;
          // skip anything that is not a full-size address attribute
          if (!((current_attr_type inside {srap_pkg::ATTR_MAPPED, srap_pkg::ATTR_XOR,
                                            srap_pkg::ATTR_RELAYED}) &&
                len_sel >= 16'd8)) begin
            next_attribute_start_next = padded_end;
          end
        end
        4'd5: value_family_next = data_byte;
        4'd6: value_port_next   = {data_byte, 8'h00};
        4'd7: value_port_next   = {value_port[15:8], data_byte};
        4'd8: value_address_next = {data_byte, 24'h000000};
        4'd9: value_address_next = {value_address[31:24], data_byte, 16'h0000};
        4'd10: value_address_next = {value_address[31:16], data_byte, 8'h00};
        4'd11: begin
          value_address_next = addr_done;
          if (value_family == srap_pkg::FAMILY_IPV4) begin
            found_flag_next = 1'b1;
            if (current_attr_type == srap_pkg::ATTR_MAPPED) begin
              found_ip_next   = addr_done;
              found_port_next = value_port;
              found_kind_next = srap_pkg::KIND_MAPPED;
            end else begin
              found_ip_next   = addr_done ^ srap_pkg::MAGIC_COOKIE;
              found_port_next = value_port ^ srap_pkg::MAGIC_COOKIE[31:16];
              found_kind_next = (current_attr_type == srap_pkg::ATTR_XOR) ?
                                srap_pkg::KIND_XOR : srap_pkg::KIND_RELAYED;
            end
          end
          next_attribute_start_next = padded_end;
        end
        default: ;
      endcase
    end

    byte_position_next = (byte_position != srap_pkg::POSITION_MAX) ?
                         byte_position + 17'd1 : byte_position;

    // checks in priority order, on state that includes this byte
    if (byte_position < 17'(srap_pkg::HEADER_BYTES - 1)) begin
      status_next = srap_pkg::STATUS_SHORT;
    end else if ((header_type_next & srap_pkg::TYPE_MASK) != srap_pkg::TYPE_BINDING) begin
      status_next = srap_pkg::STATUS_BAD_TYPE;
    end else if (!cookie_match_next) begin
      status_next = srap_pkg::STATUS_BAD_COOKIE;
    end else if (17'(header_length_next) + 17'(srap_pkg::HEADER_BYTES - 1) > byte_position) begin
      status_next = srap_pkg::STATUS_OVERRUN;
    end else if (!found_flag_next) begin
      status_next = srap_pkg::STATUS_NO_ADDRESS;
    end else begin
      status_next = srap_pkg::STATUS_OK;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      header_type          <= '0;
      header_length        <= '0;
      cookie_match         <= 1'b1;
      next_attribute_start <= 18'(srap_pkg::HEADER_BYTES);
      found_flag           <= 1'b0;
    end else if (in_accept) begin
      if (end_of_datagram) begin
        byte_position        <= '0;
        header_type          <= '0;
        header_length        <= '0;
        cookie_match         <= 1'b1;
        next_attribute_start <= 18'(srap_pkg::HEADER_BYTES);
        found_flag           <= 1'b0;
      end else begin
        byte_position        <= byte_position_next;
        header_type          <= header_type_next;
        header_length        <= header_length_next;
        cookie_match         <= cookie_match_next;
        next_attribute_start <= next_attribute_start_next;
        found_flag           <= found_flag_next;
      end
    end
  end

  // attribute payload, always written before it is read within a datagram
  always_ff @(posedge clk) begin
    if (in_accept) begin
      current_attr_type   <= current_attr_type_next;
      current_attr_length <= current_attr_length_next;
      value_family        <= value_family_next;
      value_port          <= value_port_next;
      value_address       <= value_address_next;
      found_ip            <= found_ip_next;
      found_port          <= found_port_next;
      found_kind          <= found_kind_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && end_of_datagram) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && end_of_datagram) begin
      status <= status_next;
      if (status_next == srap_pkg::STATUS_OK) begin
        mapped_ip    <= found_ip_next;
        mapped_port  <= found_port_next;
        address_kind <= found_kind_next;
      end else begin
        mapped_ip    <= '0;
        mapped_port  <= '0;
        address_kind <= srap_pkg::KIND_MAPPED;
      end
    end
  end

  `SRAP_ASSERT_SAME(a_error_fields_zero, clk, rst,
    out_valid && status != srap_pkg::STATUS_OK,
    mapped_ip == 32'd0 && mapped_port == 16'd0 && address_kind == srap_pkg::KIND_MAPPED)
  `SRAP_ASSERT_NEXT(a_restart_after_last, clk, rst,
    in_accept && end_of_datagram,
    byte_position == 17'd0 && !found_flag && cookie_match && out_valid)
  `SRAP_ASSERT_SAME(a_stall_only_when_held, clk, rst,
    in_stall, out_valid && out_stall && end_of_datagram)
  `SRAP_ASSERT_SAME(a_kind_in_range, clk, rst,
    out_valid, address_kind != 2'd3 && status <= srap_pkg::STATUS_NO_ADDRESS)

endmodule
